@@ rtl/assert_macros.svh @@
// Assertion macros shared by the palette quantizer RTL.
// Needs a clock named i_clk and a synchronous active-low reset named i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define PNQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define PNQ_ASSERT_NEXT(label, cause, effect, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cause) |=> (effect)) else $error(msg);

`endif

@@ rtl/pnq_pkg.sv @@
// Package for the palette nearest-colour quantizer.
// Holds word types, codes, grid tables and sizing constants; depends on nothing.
package pnq_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int NUM_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int CFG_SIZE_W    = 9;
    localparam int CMP_W         = (NUM_W > CFG_SIZE_W) ? NUM_W : CFG_SIZE_W;
    localparam int DIST_W        = 18;
    localparam int CFG_DATA_W    = 9;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_QUANT  = 2'd1;
    localparam logic [1:0] OP_EXPAND = 2'd2;

    localparam logic [1:0] MODE_TABLE  = 2'd0;
    localparam logic [1:0] MODE_RGB332 = 2'd1;
    localparam logic [1:0] MODE_RGB24  = 2'd2;

    localparam logic CFG_MODE = 1'b0;
    localparam logic CFG_SIZE = 1'b1;

    localparam logic [7:0] GRID8 [8] = '{8'd0, 8'd36, 8'd73, 8'd109,
                                         8'd146, 8'd182, 8'd219, 8'd255};
    localparam logic [7:0] GRID4 [4] = '{8'd0, 8'd85, 8'd170, 8'd255};

    typedef struct packed {
        logic [1:0]  opcode;
        logic [23:0] entry_index;
        logic [7:0]  red_in;
        logic [7:0]  green_in;
        logic [7:0]  blue_in;
    } t_in_word;

    typedef struct packed {
        logic [23:0] index_out;
        logic [7:0]  red_out;
        logic [7:0]  green_out;
        logic [7:0]  blue_out;
        logic        range_error;
    } t_out_word;

    typedef struct packed {
        logic [1:0]        op;
        logic              tbl;
        logic [IDX_W-1:0]  slot;
        logic              slot_ok;
        logic [23:0]       rgb;
        logic              cand_ok;
        logic [IDX_W-1:0]  cand_idx;
        logic [DIST_W-1:0] cand_d;
        logic [IDX_W-1:0]  best_idx;
        logic [DIST_W-1:0] best_d;
        logic [23:0]       res_idx;
        logic [23:0]       col;
        logic              err;
    } t_flow;

    function automatic logic [2:0] level8(input logic [7:0] v);
        logic [2:0] cnt;
        cnt = 3'd0;
        for (int k = 0; k < 7; k++) begin
            if ({v, 1'b0} > (9'(GRID8[k]) + 9'(GRID8[k+1]))) begin
                cnt = cnt + 3'd1;
            end
        end
        return cnt;
    endfunction

    function automatic logic [1:0] level4(input logic [7:0] v);
        logic [1:0] cnt;
        cnt = 2'd0;
        for (int k = 0; k < 3; k++) begin
            if ({v, 1'b0} > (9'(GRID4[k]) + 9'(GRID4[k+1]))) begin
                cnt = cnt + 2'd1;
            end
        end
        return cnt;
    endfunction

endpackage

@@ rtl/pnq_cell.sv @@
// One cell of the palette chain: holds one table entry and one word in flight.
// Depends on pnq_pkg.
module pnq_cell (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_adv,
    input  logic [pnq_pkg::IDX_W-1:0] i_cell_idx,
    input  logic [pnq_pkg::NUM_W-1:0] i_size,
    input  logic                     i_valid,
    input  pnq_pkg::t_flow           i_flow,
    output logic                     o_valid,
    output pnq_pkg::t_flow           o_flow
);
    import pnq_pkg::*;

    logic [23:0] r_entry;
    logic        r_valid;
    t_flow       r_flow;
    t_flow       n_flow;
    logic [7:0]  w_dr;
    logic [7:0]  w_dg;
    logic [7:0]  w_db;
    logic        w_hit;

    function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    assign w_dr  = absdiff(r_entry[23:16], i_flow.rgb[23:16]);
    assign w_dg  = absdiff(r_entry[15:8], i_flow.rgb[15:8]);
    assign w_db  = absdiff(r_entry[7:0], i_flow.rgb[7:0]);
    assign w_hit = i_flow.slot_ok && (i_flow.slot == i_cell_idx);

    always_comb begin
        n_flow = i_flow;
        if (i_flow.cand_ok && (i_flow.cand_d < i_flow.best_d)) begin
            n_flow.best_d   = i_flow.cand_d;
            n_flow.best_idx = i_flow.cand_idx;
        end
        n_flow.cand_d   = DIST_W'({8'd0, w_dr} * {8'd0, w_dr})
                        + DIST_W'({8'd0, w_dg} * {8'd0, w_dg})
                        + DIST_W'({8'd0, w_db} * {8'd0, w_db});
        n_flow.cand_ok  = NUM_W'(i_cell_idx) < i_size;
        n_flow.cand_idx = i_cell_idx;
        if (i_flow.op == OP_EXPAND && i_flow.tbl && w_hit) begin
            n_flow.col = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_valid && i_flow.op == OP_LOAD && w_hit) begin
            r_entry <= i_flow.rgb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_flow <= n_flow;
        end
    end

    assign o_valid = r_valid;
    assign o_flow  = r_flow;

endmodule

@@ rtl/pnq_tail.sv @@
// Tail of the palette chain: last best-distance compare and the output register.
// Depends on pnq_pkg.
module pnq_tail (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  pnq_pkg::t_flow    i_flow,
    output logic              o_valid,
    output pnq_pkg::t_out_word o_word
);
    import pnq_pkg::*;

    logic             r_valid;
    t_out_word        r_word;
    t_out_word        n_word;
    logic [IDX_W-1:0] w_best;

    always_comb begin
        w_best = i_flow.best_idx;
        if (i_flow.cand_ok && (i_flow.cand_d < i_flow.best_d)) begin
            w_best = i_flow.cand_idx;
        end
        n_word.index_out   = i_flow.res_idx;
        if (i_flow.op == OP_QUANT && i_flow.tbl) begin
            n_word.index_out = 24'(w_best);
        end
        n_word.red_out     = i_flow.col[23:16];
        n_word.green_out   = i_flow.col[15:8];
        n_word.blue_out    = i_flow.col[7:0];
        n_word.range_error = i_flow.err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

@@ rtl/palette_nearest_colour_quantizer_core.sv @@
// Top level of the palette nearest-colour quantizer: config registers, head stage,
// the chain of pnq_cell instances and pnq_tail. Depends on pnq_pkg and assert_macros.svh.
//
//   channel | direction | handshake             | word
//   --------+-----------+-----------------------+-----------
//   in      | input     | i_in_valid, o_in_stall | t_in_word
//   out     | output    | o_out_valid, i_out_stall | t_out_word
//   cfg     | input     | i_cfg_we              | i_cfg_idx, i_cfg_data
//
// Every word passes through one cell per table entry and then the output register.
// The chain takes one word per cycle while not stalled; the cell row sets this rate.
// A stalled full output register freezes the whole chain, and o_in_stall follows it.
// Reset clears the valid bits, sets table mode and a table size of 2; table entries are
// undefined until loaded.
module palette_nearest_colour_quantizer_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  pnq_pkg::t_in_word         i_in_word,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output pnq_pkg::t_out_word        o_out_word,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [pnq_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pnq_pkg::*;

    `include "assert_macros.svh"

    logic [1:0]            r_mode;
    logic [CFG_SIZE_W-1:0] r_table_size;
    logic [CMP_W-1:0]      w_size_ext;
    logic [NUM_W-1:0]      w_size;
    logic                  w_adv;
    logic                  w_tbl;
    t_flow                 w_head;
    logic                  w_valid [TABLE_ENTRIES+1];
    t_flow                 w_flow  [TABLE_ENTRIES+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_TABLE;
            r_table_size <= CFG_SIZE_W'(2);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE: r_mode       <= i_cfg_data[1:0];
                CFG_SIZE: r_table_size <= i_cfg_data[CFG_SIZE_W-1:0];
                default:  r_mode       <= r_mode;
            endcase
        end
    end

    always_comb begin
        w_size_ext = CMP_W'(r_table_size);
        if (w_size_ext < CMP_W'(2)) begin
            w_size_ext = CMP_W'(2);
        end else if (w_size_ext > CMP_W'(TABLE_ENTRIES)) begin
            w_size_ext = CMP_W'(TABLE_ENTRIES);
        end
        w_size = NUM_W'(w_size_ext);
    end

    assign w_tbl = !(r_mode == MODE_RGB332 || r_mode == MODE_RGB24);

    always_comb begin
        w_head          = '0;
        w_head.op       = i_in_word.opcode;
        w_head.tbl      = w_tbl;
        w_head.slot     = i_in_word.entry_index[IDX_W-1:0];
        w_head.rgb      = {i_in_word.red_in, i_in_word.green_in, i_in_word.blue_in};
        w_head.best_d   = '1;
        case (i_in_word.opcode)
            OP_LOAD: begin
                w_head.slot_ok = i_in_word.entry_index < 24'(TABLE_ENTRIES);
                w_head.err     = !w_head.slot_ok;
            end
            OP_QUANT: begin
                if (r_mode == MODE_RGB24) begin
                    w_head.res_idx = w_head.rgb;
                end else if (r_mode == MODE_RGB332) begin
                    w_head.res_idx = {16'd0, level8(i_in_word.red_in),
                                      level8(i_in_word.green_in), level4(i_in_word.blue_in)};
                end
            end
            OP_EXPAND: begin
                if (r_mode == MODE_RGB24) begin
                    w_head.col = i_in_word.entry_index;
                end else if (r_mode == MODE_RGB332) begin
                    if (i_in_word.entry_index[23:8] == 16'd0) begin
                        w_head.col = {GRID8[i_in_word.entry_index[7:5]],
                                      GRID8[i_in_word.entry_index[4:2]],
                                      GRID4[i_in_word.entry_index[1:0]]};
                    end else begin
                        w_head.err = 1'b1;
                    end
                end else begin
                    w_head.slot_ok = i_in_word.entry_index < 24'(w_size);
                    w_head.err     = !w_head.slot_ok;
                end
            end
            default: w_head.op = i_in_word.opcode;
        endcase
    end

    assign w_valid[0] = i_in_valid;
    assign w_flow[0]  = w_head;

    for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
        pnq_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_adv      (w_adv),
            .i_cell_idx (IDX_W'(k)),
            .i_size     (w_size),
            .i_valid    (w_valid[k]),
            .i_flow     (w_flow[k]),
            .o_valid    (w_valid[k+1]),
            .o_flow     (w_flow[k+1])
        );
    end

    pnq_tail u_tail (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_valid[TABLE_ENTRIES]),
        .i_flow  (w_flow[TABLE_ENTRIES]),
        .o_valid (o_out_valid),
        .o_word  (o_out_word)
    );

    assign w_adv      = !o_out_valid || !i_out_stall;
    assign o_in_stall = !w_adv;

    `PNQ_ASSERT(a_stall_freezes, !(o_out_valid && i_out_stall) || o_in_stall, "chain moved under stall")
    `PNQ_ASSERT(a_empty_no_stall, o_out_valid || !o_in_stall, "input stalled with empty output")
    `PNQ_ASSERT(a_err_zero_index, !(o_out_valid && o_out_word.range_error) || o_out_word.index_out == 24'd0, "error word has index")
    `PNQ_ASSERT_NEXT(a_stall_holds, o_out_valid && i_out_stall, o_out_valid, "stalled result lost")

endmodule

@@ tb/sv/palette_nearest_colour_quantizer_core_tb.sv @@
// Self-checking testbench for palette_nearest_colour_quantizer_core.
// It runs directed and random words through all modes and a mix of table sizes and checks
// each result against its own palette predictor. Depends on pnq_pkg and the core RTL.
module palette_nearest_colour_quantizer_core_tb;
    import pnq_pkg::*;

    localparam logic [1:0] OP_NONE    = 2'd3;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = TABLE_ENTRIES + 40;
    localparam int PHASES       = 12;
    localparam int PHASE_WORDS  = 120;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_word              i_in_word;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_word             o_out_word;
    logic                  i_cfg_we;
    logic                  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    palette_nearest_colour_quantizer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    class palette_scoreboard;
        logic [23:0] colours [TABLE_ENTRIES];
        logic [1:0]  mode;
        logic [8:0]  size_reg;
        t_out_word   answers [$];
        int          mismatches;
        int          checked;

        function new();
            foreach (colours[k]) colours[k] = '0;
            mode       = MODE_TABLE;
            size_reg   = 9'd2;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void set_register(logic idx, logic [8:0] data);
            if (idx == CFG_MODE) begin
                mode = data[1:0];
            end else begin
                size_reg = data;
            end
        endfunction

        function int entries_in_use();
            int n;
            n = size_reg;
            if (n < 2) n = 2;
            if (n > TABLE_ENTRIES) n = TABLE_ENTRIES;
            return n;
        endfunction

        function int grid_value(int k, bit coarse);
            if (coarse) return k * 85;
            case (k)
                0: return 0;
                1: return 36;
                2: return 73;
                3: return 109;
                4: return 146;
                5: return 182;
                6: return 219;
                default: return 255;
            endcase
        endfunction

        function int closest_step(int v, bit coarse);
            int best;
            int best_d;
            int d;
            best   = 0;
            best_d = 1 << 30;
            for (int k = 0; k < (coarse ? 4 : 8); k++) begin
                d = (grid_value(k, coarse) - v) * (grid_value(k, coarse) - v);
                if (d < best_d) begin
                    best   = k;
                    best_d = d;
                end
            end
            return best;
        endfunction

        function t_out_word palette_answer(t_in_word w);
            t_out_word   a;
            logic [23:0] e;
            logic [23:0] colour;
            int          idx;
            int          n;
            int          d;
            int          best;
            int          best_d;
            a      = '0;
            colour = '0;
            idx    = int'(w.entry_index);
            n      = entries_in_use();
            case (w.opcode)
                OP_LOAD: begin
                    if (idx < TABLE_ENTRIES) begin
                        colours[idx] = {w.red_in, w.green_in, w.blue_in};
                    end else begin
                        a.range_error = 1'b1;
                    end
                end
                OP_QUANT: begin
                    if (mode == MODE_RGB24) begin
                        a.index_out = {w.red_in, w.green_in, w.blue_in};
                    end else if (mode == MODE_RGB332) begin
                        a.index_out = 24'((closest_step(w.red_in, 0) << 5)
                                        | (closest_step(w.green_in, 0) << 2)
                                        | closest_step(w.blue_in, 1));
                    end else begin
                        best   = 0;
                        best_d = 1 << 30;
                        for (int k = 0; k < n; k++) begin
                            e = colours[k];
                            d = (int'(e[23:16]) - w.red_in) * (int'(e[23:16]) - w.red_in)
                              + (int'(e[15:8]) - w.green_in) * (int'(e[15:8]) - w.green_in)
                              + (int'(e[7:0]) - w.blue_in) * (int'(e[7:0]) - w.blue_in);
                            if (d < best_d) begin
                                best   = k;
                                best_d = d;
                            end
                        end
                        a.index_out = 24'(best);
                    end
                end
                OP_EXPAND: begin
                    if (mode == MODE_RGB24) begin
                        colour = w.entry_index;
                    end else if (mode == MODE_RGB332) begin
                        if (idx < 256) begin
                            colour = {8'(grid_value(w.entry_index[7:5], 0)),
                                      8'(grid_value(w.entry_index[4:2], 0)),
                                      8'(grid_value(w.entry_index[1:0], 1))};
                        end else begin
                            a.range_error = 1'b1;
                        end
                    end else if (idx < n) begin
                        colour = colours[idx];
                    end else begin
                        a.range_error = 1'b1;
                    end
                    {a.red_out, a.green_out, a.blue_out} = colour;
                end
                default: begin
                end
            endcase
            return a;
        endfunction

        function void note_word(t_in_word w);
            answers.insert(answers.size(), palette_answer(w));
        endfunction

        function void check_word(t_out_word got);
            t_out_word want;
            checked++;
            if (answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Unexpected result word: idx %h rgb %h%h%h err %b",
                             got.index_out, got.red_out, got.green_out, got.blue_out,
                             got.range_error);
                end
                return;
            end
            want = answers.pop_front();
            if (got.index_out !== want.index_out || got.red_out !== want.red_out
                    || got.green_out !== want.green_out || got.blue_out !== want.blue_out
                    || got.range_error !== want.range_error) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Wrong result %0d: want idx %h rgb %h%h%h err %b", checked,
                             want.index_out, want.red_out, want.green_out, want.blue_out,
                             want.range_error);
                    $display("    got idx %h rgb %h%h%h err %b", got.index_out,
                             got.red_out, got.green_out, got.blue_out, got.range_error);
                end
            end
        endfunction
    endclass

    palette_scoreboard sb;
    bit                loaded [TABLE_ENTRIES];
    bit                calm;
    int                cycles;
    int                op_count [4];
    logic [1:0] plan_mode [PHASES] = '{MODE_TABLE, MODE_RGB332, MODE_TABLE, MODE_RGB24,
                                       MODE_SPARE, MODE_TABLE, MODE_RGB332, MODE_SPARE,
                                       MODE_TABLE, MODE_RGB24, MODE_TABLE, MODE_SPARE};
    int         plan_size [PHASES] = '{2, 0, 40, 511, 1, 257, 3, 511, 256, 100, 255, 2};

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) sb.note_word(i_in_word);
            if (o_out_valid && !i_out_stall) sb.check_word(o_out_word);
        end
    end

    initial begin
        int hold;
        i_out_stall = 1'b1;
        forever begin
            hold = calm ? 0 : $urandom_range(0, 11);
            i_out_stall = (hold != 0);
            repeat (hold) @(negedge i_clk);
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (!(o_out_valid === 1'b1 && i_rst_n === 1'b1));
            @(negedge i_clk);
        end
    end

    task automatic send_word(t_in_word w);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 11);
        repeat (gap) @(negedge i_clk);
        if (w.opcode == OP_LOAD && w.entry_index < TABLE_ENTRIES) loaded[w.entry_index] = 1'b1;
        i_in_word  = w;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        op_count[w.opcode]++;
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic wait_for_results();
        while (sb.answers.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [8:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        sb.set_register(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic t_in_word make_word(logic [1:0] op, logic [23:0] idx, logic [23:0] rgb);
        t_in_word w;
        w.opcode      = op;
        w.entry_index = idx;
        {w.red_in, w.green_in, w.blue_in} = rgb;
        return w;
    endfunction

    function automatic t_in_word random_word();
        t_in_word w;
        int       pick;
        int       n;
        int       top;
        int       slot;
        bit       tbl;
        w    = make_word(OP_NONE, 24'($urandom), 24'($urandom));
        n    = sb.entries_in_use();
        tbl  = (sb.mode == MODE_TABLE) || (sb.mode == MODE_SPARE);
        pick = $urandom_range(0, 99);
        slot = -1;
        if (pick < 30) begin
            w.opcode = OP_LOAD;
            if ($urandom_range(0, 9) != 0) begin
                w.entry_index = 24'($urandom_range(0, TABLE_ENTRIES - 1));
            end else begin
                w.entry_index = 24'($urandom_range(TABLE_ENTRIES, 24'hFFFFFF));
            end
            if ($urandom_range(0, 3) == 0) begin
                {w.red_in, w.green_in, w.blue_in} = sb.colours[$urandom_range(0, TABLE_ENTRIES - 1)];
            end
        end else if (pick < 70) begin
            w.opcode = OP_QUANT;
            if (tbl && $urandom_range(0, 3) == 0) begin
                {w.red_in, w.green_in, w.blue_in} = sb.colours[$urandom_range(0, n - 1)];
            end
            if (tbl) begin
                for (int k = n - 1; k >= 0; k--) begin
                    if (!loaded[k]) slot = k;
                end
            end
        end else if (pick < 92) begin
            w.opcode = OP_EXPAND;
            if (tbl || sb.mode == MODE_RGB332) begin
                top = tbl ? n : 256;
                if ($urandom_range(0, 7) == 0) begin
                    w.entry_index = 24'($urandom_range(top, 24'hFFFFFF));
                end else begin
                    w.entry_index = 24'($urandom_range(0, top - 1));
                end
                if (tbl && w.entry_index < n && !loaded[w.entry_index]) slot = w.entry_index;
            end
        end
        // Table entries in use must be loaded before any lookup reads them.
        if (slot >= 0) begin
            w.opcode      = OP_LOAD;
            w.entry_index = 24'(slot);
        end
        return w;
    endfunction

    initial begin
        int size;
        sb         = new();
        calm       = 1'b0;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_word  = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_MODE;
        i_cfg_data = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_word(make_word(OP_LOAD, 24'd0, 24'h000000));
        send_word(make_word(OP_LOAD, 24'd1, 24'hFFFFFF));
        send_word(make_word(OP_LOAD, 24'd255, 24'h123456));
        send_word(make_word(OP_LOAD, 24'd256, 24'hABCDEF));
        send_word(make_word(OP_LOAD, 24'hFFFFFF, 24'h55AA55));
        send_word(make_word(OP_QUANT, 24'hFFFFFF, 24'h000000));
        send_word(make_word(OP_QUANT, 24'd0, 24'hFFFFFF));
        send_word(make_word(OP_QUANT, 24'd0, 24'h7F7F7F));
        send_word(make_word(OP_QUANT, 24'd0, 24'h808080));
        send_word(make_word(OP_EXPAND, 24'd1, 24'h000000));
        send_word(make_word(OP_EXPAND, 24'd2, 24'hFFFFFF));
        send_word(make_word(OP_EXPAND, 24'hFFFFFF, 24'h000000));
        send_word(make_word(OP_NONE, 24'hFFFFFF, 24'hFFFFFF));
        // Two equal entries: the lower index has to win the tie.
        send_word(make_word(OP_LOAD, 24'd1, 24'h000000));
        send_word(make_word(OP_QUANT, 24'd0, 24'h102030));

        wait_for_results();
        write_reg(CFG_MODE, 9'(MODE_RGB332));
        send_word(make_word(OP_QUANT, 24'd0, 24'h125B2A));
        send_word(make_word(OP_QUANT, 24'd0, 24'h135C2B));
        send_word(make_word(OP_QUANT, 24'd0, 24'hEDA4FF));
        send_word(make_word(OP_EXPAND, 24'd255, 24'h000000));
        send_word(make_word(OP_EXPAND, 24'd256, 24'h000000));

        wait_for_results();
        write_reg(CFG_MODE, 9'(MODE_RGB24));
        send_word(make_word(OP_QUANT, 24'd0, 24'hFFFFFF));
        send_word(make_word(OP_EXPAND, 24'hFFFFFF, 24'h000000));

        for (int p = 0; p < PHASES; p++) begin
            wait_for_results();
            size = (p == PHASES - 1) ? $urandom_range(2, TABLE_ENTRIES) : plan_size[p];
            write_reg(CFG_MODE, {7'($urandom), plan_mode[p]});
            write_reg(CFG_SIZE, 9'(size));
            calm = (p % 4 == 2);
            for (int k = 0; k < PHASE_WORDS; k++) begin
                if (p == 1 && k == PHASE_WORDS / 2) wait_for_results();
                send_word(random_word());
            end
        end
        calm = 1'b0;

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d loads, %0d quantize, %0d expand and %0d idle-opcode words",
                 op_count[OP_LOAD], op_count[OP_QUANT], op_count[OP_EXPAND],
                 op_count[OP_NONE]);
        $display("over %0d register settings; %0d result words checked, %0d wrong.",
                 PHASES + 3, sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.answers.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
